/* design/arp_request_filter_and_reply_macros.svh */
// Assertion macros used by the top-level design file.
`ifndef ARP_REQUEST_FILTER_AND_REPLY_MACROS_SVH
`define ARP_REQUEST_FILTER_AND_REPLY_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ARPRFR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("arprfr assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ARPRFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("arprfr assertion failed");

`endif

/* design/arprfr_pkg.sv */
package arprfr_pkg;

    localparam int FRAME_LEN = 42;
    localparam int POS_W     = 6;

    localparam logic [1:0] CFG_OWN_IP   = 2'd0;
    localparam logic [1:0] CFG_OWN_MAC  = 2'd1;
    localparam logic [1:0] CFG_PEER_IP  = 2'd2;
    localparam logic [1:0] CFG_PEER_MAC = 2'd3;

    localparam logic [7:0] OP_REQUEST = 8'h01;
    localparam logic [7:0] OP_REPLY   = 8'h02;
    localparam logic [7:0] BCAST_BYTE = 8'hFF;

    typedef struct packed {
        logic [31:0] own_ip;
        logic [47:0] own_mac;
        logic [31:0] peer_ip;
        logic [47:0] peer_mac;
    } t_cfg;

    // Byte k of a MAC address, first byte on the wire is the most significant.
    function automatic logic [7:0] mac_byte(input logic [47:0] v, input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = v[47:40];
            3'd1:    b = v[39:32];
            3'd2:    b = v[31:24];
            3'd3:    b = v[23:16];
            3'd4:    b = v[15:8];
            3'd5:    b = v[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ip_byte(input logic [31:0] v, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = v[31:24];
            2'd1:    b = v[23:16];
            2'd2:    b = v[15:8];
            default: b = v[7:0];
        endcase
        return b;
    endfunction

    // Ethertype, hardware type, protocol type, lengths and request opcode.
    function automatic logic [7:0] hdr_byte(input logic [3:0] k);
        logic [7:0] b;
        case (k)
            4'd0:    b = 8'h08;
            4'd1:    b = 8'h06;
            4'd2:    b = 8'h00;
            4'd3:    b = 8'h01;
            4'd4:    b = 8'h08;
            4'd5:    b = 8'h00;
            4'd6:    b = 8'h06;
            4'd7:    b = 8'h04;
            4'd8:    b = 8'h00;
            4'd9:    b = OP_REQUEST;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // True when byte b is acceptable at frame position p.
    function automatic logic byte_ok(input logic [POS_W-1:0] p, input logic [7:0] b,
                                     input t_cfg cfg);
        logic [POS_W-1:0] k;
        logic             ok;
        k  = '0;
        ok = 1'b1;
        if (p < POS_W'(6)) begin
            ok = (b == BCAST_BYTE);
        end else if (p < POS_W'(12)) begin
            ok = 1'b1;
        end else if (p < POS_W'(22)) begin
            k  = p - POS_W'(12);
            ok = (b == hdr_byte(k[3:0]));
        end else if (p < POS_W'(28)) begin
            k  = p - POS_W'(22);
            ok = (b == mac_byte(cfg.peer_mac, k[2:0]));
        end else if (p < POS_W'(32)) begin
            k  = p - POS_W'(28);
            ok = (b == ip_byte(cfg.peer_ip, k[1:0]));
        end else if (p < POS_W'(38)) begin
            ok = 1'b1;
        end else if (p < POS_W'(FRAME_LEN)) begin
            k  = p - POS_W'(38);
            ok = (b == ip_byte(cfg.own_ip, k[1:0]));
        end
        return ok;
    endfunction

    // Byte p of the reply frame.
    function automatic logic [7:0] reply_at(input logic [POS_W-1:0] p, input t_cfg cfg);
        logic [POS_W-1:0] k;
        logic [7:0]       b;
        k = '0;
        if (p < POS_W'(6)) begin
            b = mac_byte(cfg.peer_mac, p[2:0]);
        end else if (p < POS_W'(12)) begin
            k = p - POS_W'(6);
            b = mac_byte(cfg.own_mac, k[2:0]);
        end else if (p < POS_W'(22)) begin
            k = p - POS_W'(12);
            b = (p == POS_W'(21)) ? OP_REPLY : hdr_byte(k[3:0]);
        end else if (p < POS_W'(28)) begin
            k = p - POS_W'(22);
            b = mac_byte(cfg.own_mac, k[2:0]);
        end else if (p < POS_W'(32)) begin
            k = p - POS_W'(28);
            b = ip_byte(cfg.own_ip, k[1:0]);
        end else if (p < POS_W'(38)) begin
            k = p - POS_W'(32);
            b = mac_byte(cfg.peer_mac, k[2:0]);
        end else begin
            k = p - POS_W'(38);
            b = ip_byte(cfg.peer_ip, k[1:0]);
        end
        return b;
    endfunction

endpackage

/* design/arprfr_match.sv */
// Tracks the position within the received frame and whether every checked
// byte so far matched; pulses o_start when a matching frame ends.
module arprfr_match (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    input  logic                i_end,
    input  arprfr_pkg::t_cfg    i_cfg,
    output logic                o_start
);

    localparam int PW = arprfr_pkg::POS_W;

    logic [PW-1:0] r_pos, n_pos;
    logic          r_match, n_match;
    logic [PW-1:0] w_pos_inc;
    logic          w_match_inc;
    logic          w_counting;

    always_comb begin
        w_counting  = (r_pos < PW'(arprfr_pkg::FRAME_LEN));
        w_pos_inc   = w_counting ? r_pos + PW'(1) : r_pos;
        w_match_inc = r_match & (!w_counting | arprfr_pkg::byte_ok(r_pos, i_byte, i_cfg));
        o_start     = i_take && i_end && w_match_inc &&
                      (w_pos_inc == PW'(arprfr_pkg::FRAME_LEN));
        n_pos       = r_pos;
        n_match     = r_match;
        if (i_take) begin
            if (i_end) begin
                n_pos   = '0;
                n_match = 1'b1;
            end else begin
                n_pos   = w_pos_inc;
                n_match = w_match_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_match <= 1'b1;
        end else begin
            r_pos   <= n_pos;
            r_match <= n_match;
        end
    end

endmodule

/* design/arprfr_reply.sv */
// Steps through the 42 reply bytes, one each time the output register takes one.
module arprfr_reply (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_adv,
    input  arprfr_pkg::t_cfg    i_cfg,
    output logic                o_busy,
    output logic [7:0]          o_byte,
    output logic                o_end
);

    localparam int PW = arprfr_pkg::POS_W;

    logic          r_busy, n_busy;
    logic [PW-1:0] r_cnt, n_cnt;

    always_comb begin
        o_busy = r_busy;
        o_byte = arprfr_pkg::reply_at(r_cnt, i_cfg);
        o_end  = (r_cnt == PW'(arprfr_pkg::FRAME_LEN - 1));
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (r_busy && i_adv) begin
            if (o_end) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

endmodule

/* design/arp_request_filter_and_reply.sv */
// ARP responder. Received frame words enter at one per cycle and are checked
// from the input register against the broadcast destination, the ARP
// request header, the expected sender MAC and IP, and the block's own IP. A
// matching frame of at least 42 bytes, on its last word, starts a reply of
// exactly 42 words (peer MAC, own MAC, ARP reply header, own MAC and IP, peer
// MAC and IP) with the last word marked. Non-matching or short frames produce
// nothing. Throughput is one input word per cycle while no reply is in
// flight; the reply sequencer sends one word per cycle the output side does
// not stall, and while it runs the checker holds the next received word in
// the input register, so the input stalls after one further word. The last
// frame word passes the input register and the reply sequencer before the
// first reply word loads the output register. Configuration registers reset
// to zero and are written through the cfg channel, which is always ready.
`include "arp_request_filter_and_reply_macros.svh"

module arp_request_filter_and_reply (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // received frame
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_end,
    // reply frame
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_reply_byte,
    output logic        o_reply_end,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    arprfr_pkg::t_cfg r_cfg;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_end;

    logic       r_out_vld;
    logic [7:0] r_out_byte;
    logic       r_out_end;

    logic       w_in_take;
    logic       w_proc;
    logic       w_start;
    logic       w_busy;
    logic       w_out_free;
    logic       w_adv;
    logic [7:0] w_rep_byte;
    logic       w_rep_end;

    // Configuration is always accepted.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                arprfr_pkg::CFG_OWN_IP:   r_cfg.own_ip   <= i_cfg_data[31:0];
                arprfr_pkg::CFG_OWN_MAC:  r_cfg.own_mac  <= i_cfg_data;
                arprfr_pkg::CFG_PEER_IP:  r_cfg.peer_ip  <= i_cfg_data[31:0];
                arprfr_pkg::CFG_PEER_MAC: r_cfg.peer_mac <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The held word is checked whenever no reply is being sent. The input
    // register refills in the same cycle its word is checked.
    assign w_proc     = r_in_vld && !w_busy;
    assign o_in_stall = r_in_vld && w_busy;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_take) begin
            r_in_vld <= 1'b1;
        end else if (w_proc) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_frame_byte;
            r_in_end  <= i_frame_end;
        end
    end

    arprfr_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_proc),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .i_cfg   (r_cfg),
        .o_start (w_start)
    );

    arprfr_reply u_reply (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_adv   (w_adv),
        .i_cfg   (r_cfg),
        .o_busy  (w_busy),
        .o_byte  (w_rep_byte),
        .o_end   (w_rep_end)
    );

    // Output register: loads a reply word whenever it is empty or being taken.
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_adv      = w_busy && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_byte <= w_rep_byte;
            r_out_end  <= w_rep_end;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_reply_byte = r_out_byte;
    assign o_reply_end  = r_out_end;

    // A reply only starts on the final word of a frame.
    `ARPRFR_ASSERT_NOW(a_start_on_end, w_start, r_in_vld && r_in_end)
    // A new reply begins at its first word.
    `ARPRFR_ASSERT_NEXT(a_start_first, w_start, w_busy && !w_rep_end)
    // Sending the last reply word ends the sequence.
    `ARPRFR_ASSERT_NEXT(a_last_done, w_adv && w_rep_end, !w_busy)
    // A reply never starts while one is still being sent.
    `ARPRFR_ASSERT_NOW(a_no_overlap, w_busy, !w_start)

endmodule
